FILE: hdl/mvpw_pkg.sv
package mvpw_pkg;

   // sizes
   localparam int NUM_AXES_DEFAULT   = 2;
   localparam int VELOCITY_FRAC_BITS = 8;
   localparam int VEL_W              = 16;
   localparam int MAG_W              = VEL_W + 1;
   localparam int CHAN_W             = 4;
   localparam int ADDR_W             = 7;
   localparam int COUNT_W            = 13;
   localparam int PULSE_W            = 12;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 5;
   localparam int SEG_DIFF_W         = 40;
   localparam int SLOPE_W            = 7;
   localparam int PROD_W             = SEG_DIFF_W + SLOPE_W;

   // pi in 4.32 fixed point, and the scale from the velocity format to it
   localparam logic [63:0] PI_Q32   = 64'h0000_0003_243F_6A89;
   localparam int          PI_SHIFT = 32 - VELOCITY_FRAC_BITS;
   localparam logic [63:0] ROUND_UP = (64'd1 << PI_SHIFT) - 64'd1;

   // segment lower bounds as magnitudes in the velocity format (rounded up)
   localparam logic [63:0] SEG_T1  = (64'd1 * PI_Q32 + ROUND_UP) >> PI_SHIFT;
   localparam logic [63:0] SEG_T2  = (64'd2 * PI_Q32 + ROUND_UP) >> PI_SHIFT;
   localparam logic [63:0] SEG_T4  = (64'd4 * PI_Q32 + ROUND_UP) >> PI_SHIFT;
   localparam logic [63:0] SEG_T8  = (64'd8 * PI_Q32 + ROUND_UP) >> PI_SHIFT;
   localparam logic [63:0] SEG_T15 = (64'd15 * PI_Q32 + ROUND_UP) >> PI_SHIFT;

   // segment starts in 8.32 fixed point
   localparam logic [SEG_DIFF_W-1:0] SEG_K1_PI = SEG_DIFF_W'(64'd1 * PI_Q32);
   localparam logic [SEG_DIFF_W-1:0] SEG_K2_PI = SEG_DIFF_W'(64'd2 * PI_Q32);
   localparam logic [SEG_DIFF_W-1:0] SEG_K4_PI = SEG_DIFF_W'(64'd4 * PI_Q32);
   localparam logic [SEG_DIFF_W-1:0] SEG_K8_PI = SEG_DIFF_W'(64'd8 * PI_Q32);

   // slopes and bases
   localparam logic [SLOPE_W-1:0] SEG1_SLOPE = 7'd86;
   localparam logic [SLOPE_W-1:0] SEG2_SLOPE = 7'd68;
   localparam logic [SLOPE_W-1:0] SEG3_SLOPE = 7'd61;
   localparam logic [SLOPE_W-1:0] SEG4_SLOPE = 7'd104;
   localparam logic [PULSE_W-1:0] SEG1_BASE  = 12'd330;
   localparam logic [PULSE_W-1:0] SEG2_BASE  = 12'd600;
   localparam logic [PULSE_W-1:0] SEG3_BASE  = 12'd1030;
   localparam logic [PULSE_W-1:0] SEG4_BASE  = 12'd1800;
   localparam logic [PULSE_W-1:0] PULSE_MAX  = 12'd4095;

   localparam logic [COUNT_W-1:0] FULL_COUNT = 13'd4096;
   localparam logic [ADDR_W-1:0]  ADDR_BASE  = 7'd6;

   // command and status codes
   localparam logic [1:0] CMD_STOP           = 2'd0;
   localparam logic [1:0] CMD_VELOCITY       = 2'd1;
   localparam logic       STATUS_OK          = 1'b0;
   localparam logic       STATUS_UNSUPPORTED = 1'b1;

   // csr register indexes (word address)
   typedef enum logic [2:0] {
      REG_LEFT_DIR_A   = 3'd0,
      REG_LEFT_DIR_B   = 3'd1,
      REG_LEFT_SPEED   = 3'd2,
      REG_RIGHT_DIR_A  = 3'd3,
      REG_RIGHT_DIR_B  = 3'd4,
      REG_RIGHT_SPEED  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] left_dir_a;
      logic [CHAN_W-1:0] left_dir_b;
      logic [CHAN_W-1:0] left_speed;
      logic [CHAN_W-1:0] right_dir_a;
      logic [CHAN_W-1:0] right_dir_b;
      logic [CHAN_W-1:0] right_speed;
   } chan_map_type;

   typedef struct packed {
      logic [1:0]              command;
      logic                    axis;
      logic signed [VEL_W-1:0] velocity;
   } item_type;

   typedef struct packed {
      logic                    write_valid;
      logic [CHAN_W-1:0]       channel;
      logic [ADDR_W-1:0]       register_address;
      logic [COUNT_W-1:0]      on_time;
      logic [COUNT_W-1:0]      off_time;
      logic                    last;
      logic                    status;
      logic signed [VEL_W-1:0] current_velocity;
      logic signed [VEL_W-1:0] previous_velocity;
   } result_type;

   // up to three results of one command; single means only entry 0 goes out
   typedef struct packed {
      result_type [2:0] entry;
      logic             single;
   } burst_type;

   function automatic result_type make_result(
      input logic                    wv,
      input logic [CHAN_W-1:0]       ch,
      input logic [COUNT_W-1:0]      on_cnt,
      input logic [COUNT_W-1:0]      off_cnt,
      input logic                    is_last,
      input logic                    st,
      input logic signed [VEL_W-1:0] cur,
      input logic signed [VEL_W-1:0] prev
   );
      result_type r;
      r.write_valid       = wv;
      r.channel           = wv ? ch : '0;
      r.register_address  = wv ? ADDR_W'(ADDR_BASE + {1'b0, ch, 2'b00}) : '0;
      r.on_time           = on_cnt;
      r.off_time          = off_cnt;
      r.last              = is_last;
      r.status            = st;
      r.current_velocity  = cur;
      r.previous_velocity = prev;
      return r;
   endfunction

endpackage

FILE: hdl/mvpw_req_if.sv
interface mvpw_req_if
   import mvpw_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic                    axis;
   logic signed [VEL_W-1:0] velocity;

   modport source (output valid, command, axis, velocity, input ready);
   modport sink (input valid, command, axis, velocity, output ready);
endinterface

FILE: hdl/mvpw_rsp_if.sv
interface mvpw_rsp_if
   import mvpw_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    write_valid;
   logic [CHAN_W-1:0]       channel;
   logic [ADDR_W-1:0]       register_address;
   logic [COUNT_W-1:0]      on_time;
   logic [COUNT_W-1:0]      off_time;
   logic                    last;
   logic                    status;
   logic signed [VEL_W-1:0] current_velocity;
   logic signed [VEL_W-1:0] previous_velocity;

   modport source (
      output valid, write_valid, channel, register_address, on_time, off_time, last,
             status, current_velocity, previous_velocity,
      input  ready
   );
   modport sink (
      input  valid, write_valid, channel, register_address, on_time, off_time, last,
             status, current_velocity, previous_velocity,
      output ready
   );
endinterface

FILE: hdl/motor_velocity_to_pwm_writes_core.sv
// channel   direction  handshake          payload
// req_bus   in         valid / ready      command, axis, velocity
// rsp_bus   out        valid / ready      write_valid .. previous_velocity
// csr_*     in / out   psel, penable      6 channel registers at 4*i, 4 bits each
//
// stop and velocity commands give three results, an unsupported command gives one; the
// single result port sends them one at a time. each command passes the input register and
// then the result register before its first result appears.
// reset (synchronous) clears the axis history and loads the default channel map.
// a stalled result port holds the burst; one further command waits in the input register.
module motor_velocity_to_pwm_writes_core
   import mvpw_pkg::*;
#(
   parameter int NUM_AXES = NUM_AXES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   mvpw_req_if.sink              req_bus,
   mvpw_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   chan_map_type chan_map;
   burst_type    burst;
   logic         burst_valid;
   logic         burst_ready;

   // channel map registers
   mvpw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .chan_map    (chan_map)
   );

   // input register, axis history and result set
   mvpw_compute #(
      .NUM_AXES (NUM_AXES)
   ) u_compute (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .chan_map    (chan_map),
      .burst_ready (burst_ready),
      .burst_valid (burst_valid),
      .burst       (burst)
   );

   // result register and sequencing
   mvpw_burst u_burst (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst       (burst),
      .burst_ready (burst_ready),
      .rsp_bus     (rsp_bus)
   );

endmodule

FILE: hdl/mvpw_csr.sv
module mvpw_csr
   import mvpw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output chan_map_type          chan_map
);

   chan_map_type  chan_map_ff;
   chan_map_type  chan_map_in;
   reg_index_type reg_index;
   logic          write_en;
   logic [CHAN_W-1:0] wr_chan;
   logic [CHAN_W-1:0] rd_chan;

   assign reg_index  = reg_index_type'(csr_paddr[4:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign wr_chan    = csr_pwdata[CHAN_W-1:0];
   assign csr_pready = 1'b1;
   assign chan_map   = chan_map_ff;

   // register write decode
   always_comb begin
      chan_map_in = chan_map_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_LEFT_DIR_A:  chan_map_in.left_dir_a  = wr_chan;
            REG_LEFT_DIR_B:  chan_map_in.left_dir_b  = wr_chan;
            REG_LEFT_SPEED:  chan_map_in.left_speed  = wr_chan;
            REG_RIGHT_DIR_A: chan_map_in.right_dir_a = wr_chan;
            REG_RIGHT_DIR_B: chan_map_in.right_dir_b = wr_chan;
            REG_RIGHT_SPEED: chan_map_in.right_speed = wr_chan;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_map_ff.left_dir_a  <= 4'd10;
         chan_map_ff.left_dir_b  <= 4'd9;
         chan_map_ff.left_speed  <= 4'd8;
         chan_map_ff.right_dir_a <= 4'd11;
         chan_map_ff.right_dir_b <= 4'd12;
         chan_map_ff.right_speed <= 4'd13;
      end else begin
         chan_map_ff <= chan_map_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         REG_LEFT_DIR_A:  rd_chan = chan_map_ff.left_dir_a;
         REG_LEFT_DIR_B:  rd_chan = chan_map_ff.left_dir_b;
         REG_LEFT_SPEED:  rd_chan = chan_map_ff.left_speed;
         REG_RIGHT_DIR_A: rd_chan = chan_map_ff.right_dir_a;
         REG_RIGHT_DIR_B: rd_chan = chan_map_ff.right_dir_b;
         REG_RIGHT_SPEED: rd_chan = chan_map_ff.right_speed;
         default:         rd_chan = '0;
      endcase
      csr_prdata = CSR_DATA_W'(rd_chan);
   end

endmodule

FILE: hdl/mvpw_compute.sv
module mvpw_compute
   import mvpw_pkg::*;
#(
   parameter int NUM_AXES = NUM_AXES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   mvpw_req_if.sink     req_bus,
   input  chan_map_type chan_map,
   input  logic         burst_ready,
   output logic         burst_valid,
   output burst_type    burst
);

   item_type item_ff;
   logic     s1_valid_ff;
   logic     s1_valid_in;
   logic     advance;
   logic     axis_ok;

   logic signed [VEL_W-1:0] cur_ff  [NUM_AXES];
   logic signed [VEL_W-1:0] prev_ff [NUM_AXES];
   logic signed [VEL_W-1:0] cur_sel;
   logic signed [VEL_W-1:0] prev_sel;

   logic [CHAN_W-1:0] ch_a;
   logic [CHAN_W-1:0] ch_b;
   logic [CHAN_W-1:0] ch_s;

   logic [MAG_W-1:0]      mag;
   logic [63:0]           mag_wide;
   logic [SEG_DIFF_W-1:0] mag_q;
   logic [SEG_DIFF_W-1:0] kpi_sel;
   logic [SEG_DIFF_W-1:0] seg_diff;
   logic [SLOPE_W-1:0]    slope_sel;
   logic [PULSE_W-1:0]    base_sel;
   logic [PROD_W-1:0]     prod;
   logic                  seg_zero;
   logic                  seg_full;
   logic [PULSE_W-1:0]    pulse;

   logic [COUNT_W-1:0] a_on, a_off, b_on, b_off;

   // input register: holds the item until its results move to the burst stage
   assign advance       = s1_valid_ff && burst_ready;
   assign req_bus.ready = !s1_valid_ff || burst_ready;
   assign s1_valid_in   = (req_bus.valid && req_bus.ready) || (s1_valid_ff && !burst_ready);
   assign burst_valid   = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         item_ff.command  <= req_bus.command;
         item_ff.axis     <= req_bus.axis;
         item_ff.velocity <= req_bus.velocity;
      end
   end

   assign axis_ok = int'(item_ff.axis) < NUM_AXES;

   // per-axis command history
   always_comb begin
      cur_sel  = '0;
      prev_sel = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (int'(item_ff.axis) == a) begin
            cur_sel  = cur_ff[a];
            prev_sel = prev_ff[a];
         end
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      always_ff @(posedge clock) begin
         if (reset) begin
            cur_ff[a]  <= '0;
            prev_ff[a] <= '0;
         end else if (advance && int'(item_ff.axis) == a) begin
            if (item_ff.command == CMD_STOP) begin
               cur_ff[a]  <= '0;
               prev_ff[a] <= '0;
            end else if (item_ff.command == CMD_VELOCITY) begin
               prev_ff[a] <= cur_ff[a];
               cur_ff[a]  <= item_ff.velocity;
            end
         end
      end

      // a stop leaves the axis cleared
      assert property (@(posedge clock) disable iff (reset)
         advance && int'(item_ff.axis) == a && item_ff.command == CMD_STOP
         |=> cur_ff[a] == '0 && prev_ff[a] == '0)
         else $error("axis state not cleared by stop");
   end

   // channel map of the selected axis
   always_comb begin
      if (item_ff.axis) begin
         ch_a = chan_map.right_dir_a;
         ch_b = chan_map.right_dir_b;
         ch_s = chan_map.right_speed;
      end else begin
         ch_a = chan_map.left_dir_a;
         ch_b = chan_map.left_dir_b;
         ch_s = chan_map.left_speed;
      end
   end

   // magnitude and segment select
   always_comb begin
      if (item_ff.velocity[VEL_W-1]) begin
         mag = MAG_W'(17'h10000 - {1'b0, item_ff.velocity});
      end else begin
         mag = {1'b0, item_ff.velocity};
      end
      mag_wide  = 64'(mag);
      mag_q     = SEG_DIFF_W'(mag_wide << PI_SHIFT);
      seg_zero  = 1'b0;
      seg_full  = 1'b0;
      kpi_sel   = SEG_K1_PI;
      slope_sel = SEG1_SLOPE;
      base_sel  = SEG1_BASE;
      priority if (mag_wide < SEG_T1) begin
         seg_zero = 1'b1;
      end else if (mag_wide < SEG_T2) begin
         kpi_sel   = SEG_K1_PI;
         slope_sel = SEG1_SLOPE;
         base_sel  = SEG1_BASE;
      end else if (mag_wide < SEG_T4) begin
         kpi_sel   = SEG_K2_PI;
         slope_sel = SEG2_SLOPE;
         base_sel  = SEG2_BASE;
      end else if (mag_wide < SEG_T8) begin
         kpi_sel   = SEG_K4_PI;
         slope_sel = SEG3_SLOPE;
         base_sel  = SEG3_BASE;
      end else if (mag_wide < SEG_T15) begin
         kpi_sel   = SEG_K8_PI;
         slope_sel = SEG4_SLOPE;
         base_sel  = SEG4_BASE;
      end else begin
         seg_full = 1'b1;
      end
   end

   // linear segment: slope times offset, keep the integer part
   assign seg_diff = mag_q - kpi_sel;
   assign prod     = PROD_W'(slope_sel) * PROD_W'(seg_diff);

   always_comb begin
      if (seg_zero) begin
         pulse = '0;
      end else if (seg_full) begin
         pulse = PULSE_MAX;
      end else begin
         pulse = prod[32 +: PULSE_W] + base_sel;
      end
   end

   // direction pattern: release, backward or forward
   always_comb begin
      if (item_ff.velocity == '0) begin
         a_on  = '0;
         a_off = '0;
         b_on  = '0;
         b_off = '0;
      end else if (item_ff.velocity[VEL_W-1]) begin
         a_on  = FULL_COUNT;
         a_off = '0;
         b_on  = '0;
         b_off = FULL_COUNT;
      end else begin
         a_on  = '0;
         a_off = FULL_COUNT;
         b_on  = FULL_COUNT;
         b_off = '0;
      end
   end

   // result set of the item
   always_comb begin
      burst.single   = 1'b1;
      burst.entry[0] = make_result(1'b0, '0, '0, '0, 1'b1, STATUS_OK, '0, '0);
      burst.entry[1] = burst.entry[0];
      burst.entry[2] = burst.entry[0];
      if (axis_ok) begin
         unique case (item_ff.command)
            CMD_STOP: begin
               burst.single = 1'b0;
               if (item_ff.axis) begin
                  burst.entry[0] = make_result(1'b1, ch_s, '0, FULL_COUNT, 1'b0,
                                               STATUS_OK, '0, '0);
                  burst.entry[2] = make_result(1'b1, ch_a, '0, FULL_COUNT, 1'b1,
                                               STATUS_OK, '0, '0);
               end else begin
                  burst.entry[0] = make_result(1'b1, ch_a, '0, FULL_COUNT, 1'b0,
                                               STATUS_OK, '0, '0);
                  burst.entry[2] = make_result(1'b1, ch_s, '0, FULL_COUNT, 1'b1,
                                               STATUS_OK, '0, '0);
               end
               burst.entry[1] = make_result(1'b1, ch_b, '0, FULL_COUNT, 1'b0,
                                            STATUS_OK, '0, '0);
            end
            CMD_VELOCITY: begin
               burst.single   = 1'b0;
               burst.entry[0] = make_result(1'b1, ch_a, a_on, a_off, 1'b0, STATUS_OK,
                                            item_ff.velocity, cur_sel);
               burst.entry[1] = make_result(1'b1, ch_b, b_on, b_off, 1'b0, STATUS_OK,
                                            item_ff.velocity, cur_sel);
               burst.entry[2] = make_result(1'b1, ch_s, '0, {1'b0, pulse}, 1'b1,
                                            STATUS_OK, item_ff.velocity, cur_sel);
            end
            default: begin
               burst.entry[0] = make_result(1'b0, '0, '0, '0, 1'b1, STATUS_UNSUPPORTED,
                                            cur_sel, prev_sel);
            end
         endcase
      end
   end

   // a held item stays put while the burst stage is busy
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !burst_ready |=> s1_valid_ff && $stable(item_ff))
      else $error("held item changed while stalled");

endmodule

FILE: hdl/mvpw_burst.sv
module mvpw_burst
   import mvpw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        burst_valid,
   input  burst_type   burst,
   output logic        burst_ready,
   mvpw_rsp_if.source  rsp_bus
);

   burst_type  burst_ff;
   logic       valid_ff;
   logic       valid_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       take;
   logic       done;
   logic       load;
   result_type out_entry;

   // result register: walks through the stored results one transfer at a time
   assign take        = valid_ff && rsp_bus.ready;
   assign done        = take && (burst_ff.single || idx_ff == 2'd2);
   assign burst_ready = !valid_ff || done;
   assign load        = burst_valid && burst_ready;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (done) begin
         valid_in = 1'b0;
         idx_in   = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         burst_ff <= burst;
      end
   end

   // output drive
   assign out_entry                 = burst_ff.entry[idx_ff];
   assign rsp_bus.valid             = valid_ff;
   assign rsp_bus.write_valid       = out_entry.write_valid;
   assign rsp_bus.channel           = out_entry.channel;
   assign rsp_bus.register_address  = out_entry.register_address;
   assign rsp_bus.on_time           = out_entry.on_time;
   assign rsp_bus.off_time          = out_entry.off_time;
   assign rsp_bus.last              = out_entry.last;
   assign rsp_bus.status            = out_entry.status;
   assign rsp_bus.current_velocity  = out_entry.current_velocity;
   assign rsp_bus.previous_velocity = out_entry.previous_velocity;

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && burst_ff.single |-> idx_ff == 2'd0)
      else $error("single result burst advanced its index");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff != 2'd3)
      else $error("burst index out of range");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !take |=> valid_ff && $stable(idx_ff))
      else $error("burst moved without a transfer");

endmodule
